// ===== src/rbab_pkg.sv =====
// Package for the rotated bilinear alpha blitter: payload structs, register
// indexes, size constants and the blend helper. No dependencies.
package rbab_pkg;

   localparam int DEF_MAX_SRC_WIDTH = 256;
   localparam int DEF_MAX_SRC_HEIGHT = 256;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COS_ROT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_ROT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TEXEL_STEP = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = 3'd6;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_COMPOSITE = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [11:0] coord_x;
      logic [11:0] coord_y;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       covered;
   } rsp_type;

   // floor(num / (255*65536)) saturated to 255; num < 2^33.
   // q = floor(floor(num/65536) * 257 / 65536) estimate, then correct upward.
   function automatic logic [7:0] blend_div(input logic [32:0] num);
      logic [16:0] hi;
      logic [25:0] pr;
      logic [9:0]  q;
      logic [42:0] rem;
      hi = num[32:16];
      pr = 26'(hi) * 26'd257;
      q = pr[25:16];
      rem = 43'(num) - 43'(q) * 43'd16711680;
      if (rem >= 43'd16711680) q = q + 10'd1;
      rem = 43'(num) - 43'(q) * 43'd16711680;
      if (rem >= 43'd16711680) q = q + 10'd1;
      blend_div = (q > 10'd255) ? 8'd255 : q[7:0];
   endfunction

endpackage

// ===== src/rotated_bilinear_alpha_blit.sv =====
// Top level of the rotated, scaled bilinear source-over blitter.
// Depends on rbab_pkg, rbab_ram, rbab_geom and rbab_blend.
//
// Usage: req_* carries requests. A write request (operation 0) stores one
// premultiplied RGBA texel and gives no response. A composite request
// (operation 1) carries a destination pixel and its current color and gives
// exactly one response on rsp_*, with the blended color and a covered flag.
// Registers are written through csr_wr_en/csr_index/csr_wdata while idle.
// Throughput: one request per cycle while responses are not stalled. From
// request to response the pipeline runs coordinate math, then the texel read
// (four banked RAM copies, one per bilinear tap, written together at the
// read stage so writes and reads stay in request order), then filtering
// and blending, the last stage of which is the output register.
// The whole pipeline advances as one unit; a stalled response holds the
// pipeline and raises req_stall, and a new request is still taken whenever
// the output register is empty or being drained.
// Reset clears registers to their defaults and empties the pipeline; texel
// memory is left as is and must be written before use.
module rotated_bilinear_alpha_blit
   import rbab_pkg::*;
#(
   parameter int MAX_SRC_WIDTH = DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int XW = $clog2(MAX_SRC_WIDTH);
   localparam int YW = $clog2(MAX_SRC_HEIGHT);
   localparam int AW = XW + YW;
   localparam int DEPTH = 1 << AW;

   logic [15:0] center_x_ff, center_y_ff, cos_rot_ff, sin_rot_ff, texel_step_ff;
   logic [8:0] src_width_ff, src_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         cos_rot_ff <= 16'd16384;
         sin_rot_ff <= '0;
         texel_step_ff <= 16'd256;
         src_width_ff <= 9'd1;
         src_height_ff <= 9'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_CENTER_X: center_x_ff <= csr_wdata;
            REG_CENTER_Y: center_y_ff <= csr_wdata;
            REG_COS_ROT: cos_rot_ff <= csr_wdata;
            REG_SIN_ROT: sin_rot_ff <= csr_wdata;
            REG_TEXEL_STEP: texel_step_ff <= csr_wdata;
            REG_SRC_WIDTH: src_width_ff <= csr_wdata[8:0];
            REG_SRC_HEIGHT: src_height_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic acc;
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;
   assign acc = req_valid && adv;

   logic g_valid, g_hit;
   req_type g_req;
   logic [XW-1:0] x0, x1;
   logic [YW-1:0] y0, y1;
   logic [7:0] wx, wy;

   rbab_geom #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)) u_geom (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(acc), .in_req(req_payload),
      .center_x(center_x_ff), .center_y(center_y_ff), .cos_rot(cos_rot_ff),
      .sin_rot(sin_rot_ff), .texel_step(texel_step_ff), .src_width(src_width_ff),
      .src_height(src_height_ff), .out_valid(g_valid), .out_req(g_req), .out_hit(g_hit),
      .out_x0(x0), .out_x1(x1), .out_y0(y0), .out_y1(y1), .out_wx(wx), .out_wy(wy)
   );

   // texel write at the read stage
   logic wr_en;
   logic [AW-1:0] wr_addr;
   assign wr_en = adv && g_valid && g_req.operation == OP_WRITE
                  && 32'(g_req.coord_x) < MAX_SRC_WIDTH
                  && 32'(g_req.coord_y) < MAX_SRC_HEIGHT;
   assign wr_addr = {g_req.coord_y[YW-1:0], g_req.coord_x[XW-1:0]};

   // read stage: held address on stall keeps the read data stable
   logic [AW-1:0] ra [4];
   logic [AW-1:0] ra_ff [4];
   logic [31:0] rd [4];
   always_comb begin
      ra[0] = {y0, x0};
      ra[1] = {y0, x1};
      ra[2] = {y1, x0};
      ra[3] = {y1, x1};
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) ra_ff[k] <= ra[k];
      end
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      rbab_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
         .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr),
         .wr_data({g_req.in_alpha, g_req.in_blue, g_req.in_green, g_req.in_red}),
         .rd_addr(adv ? ra[b] : ra_ff[b]), .rd_data(rd[b])
      );
   end

   logic r_v_ff, r_hit_ff;
   req_type r_req_ff;
   logic [7:0] r_wx_ff, r_wy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
      end else if (adv) begin
         r_v_ff <= g_valid;
      end
      if (adv) begin
         r_req_ff <= g_req;
         r_hit_ff <= g_hit;
         r_wx_ff <= wx;
         r_wy_ff <= wy;
      end
   end

   rbab_blend u_blend (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(r_v_ff), .in_req(r_req_ff),
      .in_hit(r_hit_ff), .wx(r_wx_ff), .wy(r_wy_ff), .t00(rd[0]), .t01(rd[1]),
      .t10(rd[2]), .t11(rd[3]), .out_valid(rsp_valid), .out_rsp(rsp_payload)
   );

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall) else $error("needless request stall");
   a_wr: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> adv && g_valid && g_req.operation == OP_WRITE) else $error("stray texel write");
endmodule

// ===== src/rbab_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rbab_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== src/rbab_geom.sv =====
// Coordinate pipeline: rotate, scale, coverage test and texel addressing.
// Depends on rbab_pkg.
module rbab_geom
   import rbab_pkg::*;
#(
   parameter int MAX_SRC_WIDTH = DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
   localparam int XW = $clog2(MAX_SRC_WIDTH),
   localparam int YW = $clog2(MAX_SRC_HEIGHT)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  req_type       in_req,
   input  logic [15:0]   center_x,
   input  logic [15:0]   center_y,
   input  logic [15:0]   cos_rot,
   input  logic [15:0]   sin_rot,
   input  logic [15:0]   texel_step,
   input  logic [8:0]    src_width,
   input  logic [8:0]    src_height,
   output logic          out_valid,
   output req_type       out_req,
   output logic          out_hit,
   output logic [XW-1:0] out_x0,
   output logic [XW-1:0] out_x1,
   output logic [YW-1:0] out_y0,
   output logic [YW-1:0] out_y1,
   output logic [7:0]    out_wx,
   output logic [7:0]    out_wy
);
   localparam int SWW = XW + 1;
   localparam int SHW = YW + 1;

   logic [SWW-1:0] sw;
   logic [SHW-1:0] sh;
   logic drawable;

   always_comb begin
      if (src_width == 9'd0) sw = SWW'(1);
      else if (32'(src_width) > MAX_SRC_WIDTH) sw = SWW'(MAX_SRC_WIDTH);
      else sw = SWW'(src_width);
      if (src_height == 9'd0) sh = SHW'(1);
      else if (32'(src_height) > MAX_SRC_HEIGHT) sh = SHW'(MAX_SRC_HEIGHT);
      else sh = SHW'(src_height);
      drawable = texel_step != 16'd0 && 32'(texel_step) <= 32'(sw) * 256
                 && 32'(texel_step) <= 32'(sh) * 256;
   end

   // stage 1: offsets and four products
   logic s1_v_ff, s1_draw_ff;
   req_type s1_req_ff;
   logic signed [33:0] p_xc_ff, p_ys_ff, p_yc_ff, p_xs_ff;
   logic signed [16:0] rx, ry;
   always_comb begin
      rx = $signed({1'b0, in_req.coord_x, 4'd8}) - $signed({1'b0, center_x});
      ry = $signed({1'b0, in_req.coord_y, 4'd8}) - $signed({1'b0, center_y});
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= in_valid;
      end
      if (adv) begin
         s1_req_ff <= in_req;
         s1_draw_ff <= drawable;
         p_xc_ff <= 34'(rx) * 34'($signed(cos_rot));
         p_ys_ff <= 34'(ry) * 34'($signed(sin_rot));
         p_yc_ff <= 34'(ry) * 34'($signed(cos_rot));
         p_xs_ff <= 34'(rx) * 34'($signed(sin_rot));
      end
   end

   // stage 2: sums
   logic s2_v_ff, s2_draw_ff;
   req_type s2_req_ff;
   logic signed [34:0] lx_ff, ly_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
      if (adv) begin
         s2_req_ff <= s1_req_ff;
         s2_draw_ff <= s1_draw_ff;
         lx_ff <= 35'(p_xc_ff) + 35'(p_ys_ff);
         ly_ff <= 35'(p_yc_ff) - 35'(p_xs_ff);
      end
   end

   // stage 3: scale (35 x 17 split into two partial products)
   logic s3_v_ff, s3_draw_ff;
   req_type s3_req_ff;
   logic signed [52:0] ulo_ff, uhi_ff, vlo_ff, vhi_ff;
   logic signed [16:0] step_s;
   assign step_s = $signed({1'b0, texel_step});
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
      if (adv) begin
         s3_req_ff <= s2_req_ff;
         s3_draw_ff <= s2_draw_ff;
         ulo_ff <= 53'($signed({1'b0, lx_ff[16:0]})) * 53'(step_s);
         uhi_ff <= 53'($signed(lx_ff[34:17])) * 53'(step_s);
         vlo_ff <= 53'($signed({1'b0, ly_ff[16:0]})) * 53'(step_s);
         vhi_ff <= 53'($signed(ly_ff[34:17])) * 53'(step_s);
      end
   end

   // stage 4: combine, offset, range test
   logic signed [55:0] u, v;
   always_comb begin
      u = 56'(uhi_ff) * 56'sd131072 + 56'(ulo_ff) + (56'(sw) <<< 25);
      v = 56'(vhi_ff) * 56'sd131072 + 56'(vlo_ff) + (56'(sh) <<< 25);
   end
   logic s4_v_ff, s4_hit_ff;
   req_type s4_req_ff;
   logic [37:0] fu_ff, fv_ff;
   logic [SWW-1:0] s4_sw_ff;
   logic [SHW-1:0] s4_sh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s4_v_ff <= s3_v_ff;
      end
      if (adv) begin
         s4_req_ff <= s3_req_ff;
         s4_hit_ff <= s3_draw_ff && s3_req_ff.operation == OP_COMPOSITE && u >= 0 && v >= 0
                      && u < (56'(sw) <<< 26) && v < (56'(sh) <<< 26);
         fu_ff <= u[55:18];
         fv_ff <= v[55:18];
         s4_sw_ff <= sw;
         s4_sh_ff <= sh;
      end
   end

   // stage 5: clamp and split
   logic [37:0] cu, cv, limu, limv;
   logic [SWW-1:0] xi0;
   logic [SHW-1:0] yi0;
   always_comb begin
      limu = 38'(s4_sw_ff - SWW'(1)) << 8;
      limv = 38'(s4_sh_ff - SHW'(1)) << 8;
      cu = (fu_ff > limu) ? limu : fu_ff;
      cv = (fv_ff > limv) ? limv : fv_ff;
      xi0 = SWW'(cu >> 8);
      yi0 = SHW'(cv >> 8);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (adv) begin
         out_valid <= s4_v_ff;
      end
      if (adv) begin
         out_req <= s4_req_ff;
         out_hit <= s4_hit_ff;
         out_x0 <= xi0[XW-1:0];
         out_y0 <= yi0[YW-1:0];
         out_x1 <= (xi0 + SWW'(1) < s4_sw_ff) ? XW'(xi0 + SWW'(1)) : xi0[XW-1:0];
         out_y1 <= (yi0 + SHW'(1) < s4_sh_ff) ? YW'(yi0 + SHW'(1)) : yi0[YW-1:0];
         out_wx <= cu[7:0];
         out_wy <= cv[7:0];
      end
   end
endmodule

// ===== src/rbab_blend.sv =====
// Bilinear filter and premultiplied source-over blend, pipelined.
// Depends on rbab_pkg.
module rbab_blend
   import rbab_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  req_type     in_req,
   input  logic        in_hit,
   input  logic [7:0]  wx,
   input  logic [7:0]  wy,
   input  logic [31:0] t00,
   input  logic [31:0] t01,
   input  logic [31:0] t10,
   input  logic [31:0] t11,
   output logic        out_valid,
   output rsp_type     out_rsp
);
   // stage A: weights
   logic a_v_ff, a_hit_ff;
   req_type a_req_ff;
   logic [16:0] w00_ff, w01_ff, w10_ff, w11_ff;
   logic [31:0] a_t00_ff, a_t01_ff, a_t10_ff, a_t11_ff;
   logic [8:0] iwx, iwy;
   assign iwx = 9'd256 - 9'(wx);
   assign iwy = 9'd256 - 9'(wy);
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= in_valid;
      end
      if (adv) begin
         a_req_ff <= in_req;
         a_hit_ff <= in_hit;
         w00_ff <= 17'(iwx) * 17'(iwy);
         w01_ff <= 17'(wx) * 17'(iwy);
         w10_ff <= 17'(iwx) * 17'(wy);
         w11_ff <= 17'(wx) * 17'(wy);
         a_t00_ff <= t00;
         a_t01_ff <= t01;
         a_t10_ff <= t10;
         a_t11_ff <= t11;
      end
   end

   // stage B: samples
   logic b_v_ff, b_hit_ff;
   req_type b_req_ff;
   logic [24:0] smp_ff [4];
   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (adv) begin
         b_v_ff <= a_v_ff;
      end
      if (adv) begin
         b_req_ff <= a_req_ff;
         b_hit_ff <= a_hit_ff;
         for (int k = 0; k < 4; k++) begin
            smp_ff[k] <= 25'(a_t00_ff[8*k +: 8]) * 25'(w00_ff)
                       + 25'(a_t01_ff[8*k +: 8]) * 25'(w01_ff)
                       + 25'(a_t10_ff[8*k +: 8]) * 25'(w10_ff)
                       + 25'(a_t11_ff[8*k +: 8]) * 25'(w11_ff);
         end
      end
   end

   // stage C: numerators
   logic c_v_ff, c_cov_ff;
   req_type c_req_ff;
   logic [32:0] num_ff [4];
   logic [7:0] dch [4];
   logic [24:0] inv_a;
   always_comb begin
      dch[0] = b_req_ff.in_red;
      dch[1] = b_req_ff.in_green;
      dch[2] = b_req_ff.in_blue;
      dch[3] = b_req_ff.in_alpha;
      inv_a = 25'd16711680 - smp_ff[3];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (adv) begin
         c_v_ff <= b_v_ff && b_req_ff.operation == OP_COMPOSITE;
      end
      if (adv) begin
         c_req_ff <= b_req_ff;
         c_cov_ff <= b_hit_ff && smp_ff[3] >= 25'd32768;
         for (int k = 0; k < 4; k++) begin
            num_ff[k] <= 33'(smp_ff[k]) * 33'd255 + 33'(dch[k]) * 33'(inv_a) + 33'd8355840;
         end
      end
   end

   // stage D: divide and select
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (adv) begin
         out_valid <= c_v_ff;
      end
      if (adv) begin
         out_rsp.covered <= c_cov_ff;
         out_rsp.out_red <= c_cov_ff ? blend_div(num_ff[0]) : c_req_ff.in_red;
         out_rsp.out_green <= c_cov_ff ? blend_div(num_ff[1]) : c_req_ff.in_green;
         out_rsp.out_blue <= c_cov_ff ? blend_div(num_ff[2]) : c_req_ff.in_blue;
         out_rsp.out_alpha <= c_cov_ff ? blend_div(num_ff[3]) : c_req_ff.in_alpha;
      end
   end

   a_uncov: assert property (@(posedge clock) disable iff (reset)
      adv && c_v_ff && !c_cov_ff |=> !out_rsp.covered) else $error("uncovered result had coverage");
   a_cov_hit: assert property (@(posedge clock) disable iff (reset)
      adv && b_v_ff && !b_hit_ff |=> !c_cov_ff) else $error("coverage without hit");
   a_out_comp: assert property (@(posedge clock) disable iff (reset)
      adv && c_v_ff |=> out_valid) else $error("composite result lost");
endmodule
